### hw/rtl/pdrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdrl_pkg;

    localparam int TIMER_BITS_DEF = 16;

    localparam int DUTY_W     = 7;
    localparam int REQ_W      = 16;
    localparam int CMP_W      = 17;
    localparam int TOP_W      = 16;
    localparam int INTERVAL_W = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DUTY_W-1:0]     PCT_MAX      = 7'd100;
    localparam logic [DUTY_W-1:0]     STEP_RST     = 7'd5;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd100;
    localparam logic [TOP_W-1:0]      TOP_RST      = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_TOP     = 2'd2;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [REQ_W-1:0]  duty_request;
    } item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_now;
        logic [DUTY_W-1:0] duty_target;
        logic [CMP_W-1:0]  compare_u;
        logic [CMP_W-1:0]  compare_v;
        logic              compare_updated;
    } result_t;

endpackage

`default_nettype wire

### hw/rtl/pwm_duty_ramp_limiter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Signals                                   | Transfer
// ----------+-------------------------------------------+-------------------------
// item      | item_valid, item_ready, item (item_t)     | valid & ready at clk rise
// result    | result_valid, result_ready, result        | valid & ready at clk rise
// config    | cfg_write, cfg_index, cfg_data            | cfg_write at clk rise
//
// Accepts one request per cycle unless stalled; results pass s1, s2 and result regs.
// Ramp state updates in the accept cycle, the period products in the next stage,
// the constant divide by 100 (reciprocal multiply) in the result stage.
// Stalls on result_ready back up stage by stage; empty stages keep accepting.
// rst_n clears ramp, valid and result state; config takes its documented reset values.

module pwm_duty_ramp_limiter
    import pdrl_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire item_t                 item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output result_t                    result,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    localparam int TW  = (TIMER_BITS < TOP_W) ? TIMER_BITS : TOP_W;
    localparam int T1W = TW + 1;
    localparam int PW  = T1W + DUTY_W;
    localparam int K   = PW + DUTY_W;
    localparam int RW  = K - 6;
    localparam longint unsigned RECIP = ((64'd1 << K) + 64'd99) / 64'd100;
    localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

    logic [DUTY_W-1:0]     step_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [TOP_W-1:0]      top_reg;

    logic [DUTY_W-1:0]     duty_reg;
    logic [DUTY_W-1:0]     target_reg;
    logic [INTERVAL_W-1:0] elapsed_reg;
    logic [DUTY_W-1:0]     duty_next;
    logic [DUTY_W-1:0]     target_next;
    logic [INTERVAL_W-1:0] elapsed_next;
    logic                  changed;

    logic [INTERVAL_W:0]   tick_cnt;
    logic [DUTY_W:0]       up_sum;
    logic [DUTY_W-1:0]     down_gap;

    logic                  s1_valid_reg;
    logic [DUTY_W-1:0]     s1_duty_reg;
    logic [DUTY_W-1:0]     s1_target_reg;
    logic                  s1_upd_reg;

    logic                  s2_valid_reg;
    logic [DUTY_W-1:0]     s2_duty_reg;
    logic [DUTY_W-1:0]     s2_target_reg;
    logic                  s2_upd_reg;
    logic [PW-1:0]         s2_pu_reg;
    logic [PW-1:0]         s2_pv_reg;

    logic                  result_valid_reg;
    result_t               result_reg;
    result_t               result_next;

    logic                  out_en;
    logic                  s2_en;
    logic                  s1_en;
    logic                  item_fire;

    logic [T1W-1:0]        top1;
    logic [DUTY_W-1:0]     s1_duty_v;
    logic [PW+RW-1:0]      prod_u;
    logic [PW+RW-1:0]      prod_v;
    logic [T1W-1:0]        quot_u;
    logic [T1W-1:0]        quot_v;

    assign out_en     = !result_valid_reg || result_ready;
    assign s2_en      = !s2_valid_reg || out_en;
    assign s1_en      = !s1_valid_reg || s2_en;
    assign item_ready = s1_en;
    assign item_fire  = item_valid && s1_en;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= STEP_RST;
            interval_reg <= INTERVAL_RST;
            top_reg      <= TOP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STEP_SIZE:     step_reg     <= cfg_data[DUTY_W-1:0];
                REG_STEP_INTERVAL: interval_reg <= cfg_data[INTERVAL_W-1:0];
                REG_TIMER_TOP:     top_reg      <= cfg_data[TOP_W-1:0];
                default:           ;
            endcase
        end
    end

    // ramp decision for the incoming request
    always_comb
    begin
        duty_next    = duty_reg;
        target_next  = target_reg;
        elapsed_next = elapsed_reg;
        tick_cnt     = {1'b0, elapsed_reg} + (INTERVAL_W + 1)'(1);
        up_sum       = {1'b0, duty_reg} + {1'b0, step_reg};
        down_gap     = duty_reg - target_reg;
        if (item.operation == OP_SET)
        begin
            target_next = (item.duty_request > REQ_W'(PCT_MAX)) ?
                          PCT_MAX : item.duty_request[DUTY_W-1:0];
        end
        else if (tick_cnt >= {1'b0, interval_reg})
        begin
            elapsed_next = '0;
            if (target_reg > duty_reg)
            begin
                duty_next = (up_sum > {1'b0, target_reg}) ?
                            target_reg : up_sum[DUTY_W-1:0];
            end
            else if (target_reg < duty_reg)
            begin
                duty_next = (down_gap > step_reg) ? (duty_reg - step_reg) : target_reg;
            end
        end
        else
        begin
            elapsed_next = tick_cnt[INTERVAL_W-1:0];
        end
        changed = (duty_next != duty_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg    <= '0;
            target_reg  <= '0;
            elapsed_reg <= '0;
        end
        else if (item_fire)
        begin
            duty_reg    <= duty_next;
            target_reg  <= target_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_en)
            begin
                result_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_duty_reg   <= duty_next;
            s1_target_reg <= target_next;
            s1_upd_reg    <= changed;
        end
    end

    // period products
    assign top1      = T1W'(top_reg[TW-1:0]) + T1W'(1);
    assign s1_duty_v = PCT_MAX - s1_duty_reg;

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            s2_duty_reg   <= s1_duty_reg;
            s2_target_reg <= s1_target_reg;
            s2_upd_reg    <= s1_upd_reg;
            s2_pu_reg     <= PW'(top1) * PW'(s1_duty_reg);
            s2_pv_reg     <= PW'(top1) * PW'(s1_duty_v);
        end
    end

    // divide by 100 through the reciprocal; hold compares when duty is unchanged
    assign prod_u = (PW + RW)'(s2_pu_reg) * (PW + RW)'(RECIP_V);
    assign prod_v = (PW + RW)'(s2_pv_reg) * (PW + RW)'(RECIP_V);
    assign quot_u = prod_u[K +: T1W];
    assign quot_v = prod_v[K +: T1W];

    always_comb
    begin
        result_next.duty_now        = s2_duty_reg;
        result_next.duty_target     = s2_target_reg;
        result_next.compare_updated = s2_upd_reg;
        result_next.compare_u       = s2_upd_reg ? CMP_W'(quot_u) : result_reg.compare_u;
        result_next.compare_v       = s2_upd_reg ? CMP_W'(quot_v) : result_reg.compare_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (out_en && s2_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pdrl_check.sv
`timescale 1ns / 1ps
`default_nettype none

module pdrl_check
    import pdrl_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_ready,
    input wire item_t   item,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire result_t result
);

    localparam logic [CMP_W-1:0] CMP_LIMIT = 17'h10000;

    // hold a waiting request
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
        else $error("waiting request changed");

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.duty_now <= PCT_MAX && result.duty_target <= PCT_MAX)
        else $error("duty out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.compare_updated && result.duty_now == '0
        |-> result.compare_u == '0)
        else $error("zero duty with nonzero U compare");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.compare_updated
        |-> result.compare_u <= CMP_LIMIT && result.compare_v <= CMP_LIMIT)
        else $error("compare beyond one period");

endmodule

bind pwm_duty_ramp_limiter pdrl_check u_pdrl_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

### tb/pwm_duty_ramp_limiter_test.sv
`timescale 1ns / 1ps

module pwm_duty_ramp_limiter_test;
    import pdrl_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int REPORT_MAX  = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_ready;
    item_t                item;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    logic [DUTY_W-1:0]     step_pct_reg;
    logic [INTERVAL_W-1:0] interval_ms_reg;
    logic [TOP_W-1:0]      timer_top_reg;
    logic [DUTY_W-1:0]     duty_pct;
    logic [DUTY_W-1:0]     target_pct;
    logic [INTERVAL_W-1:0] elapsed_ms;
    logic [CMP_W-1:0]      held_u;
    logic [CMP_W-1:0]      held_v;

    result_t pending_duty_results[$];
    int      mismatches;
    int      cycle_count;
    bit      calm;

    pwm_duty_ramp_limiter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_ready <= calm || ($urandom_range(99) >= 18);
    end

    function automatic logic [CMP_W-1:0] scale_compare(input int unsigned pct);
        longint unsigned period;
        period = timer_top_reg;
        period = ((period + 1) * pct) / 100;
        return period[CMP_W-1:0];
    endfunction

    function automatic result_t predict_ramp_result(input item_t req);
        result_t     res;
        int unsigned count;
        int unsigned now_pct;
        int unsigned goal_pct;
        int unsigned step;
        int unsigned next_pct;
        bit          changed;
        changed = 1'b0;
        if (req.operation == OP_SET)
        begin
            target_pct = (req.duty_request > PCT_MAX) ? PCT_MAX : req.duty_request[DUTY_W-1:0];
        end
        else
        begin
            count = elapsed_ms + 1;
            if (count >= interval_ms_reg)
            begin
                elapsed_ms = '0;
                now_pct = duty_pct;
                goal_pct = target_pct;
                step = step_pct_reg;
                next_pct = now_pct;
                if (goal_pct > now_pct)
                begin
                    next_pct = (now_pct + step > goal_pct) ? goal_pct : now_pct + step;
                end
                else if (goal_pct < now_pct)
                begin
                    next_pct = (now_pct - goal_pct > step) ? now_pct - step : goal_pct;
                end
                if (next_pct != now_pct)
                begin
                    changed = 1'b1;
                    duty_pct = next_pct[DUTY_W-1:0];
                    held_u = scale_compare(next_pct);
                    held_v = scale_compare(100 - next_pct);
                end
            end
            else
            begin
                elapsed_ms = count[INTERVAL_W-1:0];
            end
        end
        res.duty_now = duty_pct;
        res.duty_target = target_pct;
        res.compare_u = held_u;
        res.compare_v = held_v;
        res.compare_updated = changed;
        return res;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_duty_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: %p", result);
            end
            else
            begin
                want = pending_duty_results.pop_front();
                if (result.duty_now !== want.duty_now
                    || result.duty_target !== want.duty_target
                    || result.compare_u !== want.compare_u
                    || result.compare_v !== want.compare_v
                    || result.compare_updated !== want.compare_updated)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch at cycle %0d: expected %p, got %p",
                                 cycle_count, want, result);
                end
            end
        end
    end

    task automatic send_request(input logic op, input logic [REQ_W-1:0] req);
        item_t next_item;
        next_item.operation = op;
        next_item.duty_request = req;
        item_valid <= 1'b1;
        item <= next_item;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pending_duty_results.push_back(predict_ramp_result(next_item));
        if (!calm && $urandom_range(99) < 18)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (pending_duty_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        case (index)
            REG_STEP_SIZE:     step_pct_reg = data[DUTY_W-1:0];
            REG_STEP_INTERVAL: interval_ms_reg = data;
            REG_TIMER_TOP:     timer_top_reg = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] step_data,
                                  input logic [CFG_W-1:0] interval_data,
                                  input logic [CFG_W-1:0] top_data);
        drain_results();
        write_register(REG_STEP_SIZE, step_data);
        write_register(REG_STEP_INTERVAL, interval_data);
        write_register(REG_TIMER_TOP, top_data);
        cfg_write <= 1'b0;
    endtask

    task automatic test_after_reset();
        send_request(OP_TICK, 16'hFFFF);
        send_request(OP_SET, 16'hFFFF);
    endtask

    task automatic test_ramp_up_clamp();
        apply_settings(16'd30, 16'd1, 16'hFFFF);
        repeat (5) send_request(OP_TICK, 16'h0000);
    endtask

    task automatic test_ramp_down_clamp();
        apply_settings(16'd30, 16'd1, 16'd1000);
        send_request(OP_SET, 16'd7);
        repeat (4) send_request(OP_TICK, 16'h5A5A);
    endtask

    task automatic test_zero_step_and_interval();
        apply_settings(16'd0, 16'd0, 16'd0);
        send_request(OP_SET, 16'd50);
        repeat (2) send_request(OP_TICK, 16'hA5A5);
    endtask

    task automatic test_interval_lowered();
        apply_settings(16'hFF7F, 16'hFFFF, 16'd0);
        repeat (2) send_request(OP_TICK, 16'h0000);
        send_request(OP_SET, 16'd100);
        apply_settings(16'hFF7F, 16'd1, 16'd0);
        send_request(OP_TICK, 16'h0000);
        send_request(OP_SET, 16'd0);
        send_request(OP_TICK, 16'h0000);
    endtask

    task automatic test_random_ramps(input int phases, input int per_phase);
        logic [CFG_W-1:0] step_data;
        logic [CFG_W-1:0] interval_data;
        logic [CFG_W-1:0] top_data;
        logic [REQ_W-1:0] req;
        logic             op;
        int               pick;
        for (int p = 0; p < phases; p++)
        begin
            case ($urandom_range(9))
                0:       step_data = 16'd0;
                1:       step_data = 16'($urandom);
                2:       step_data = 16'd100;
                default: step_data = 16'($urandom_range(1, 40));
            endcase
            case ($urandom_range(9))
                0:       interval_data = 16'd0;
                1:       interval_data = 16'($urandom_range(20, 200));
                default: interval_data = 16'($urandom_range(1, 6));
            endcase
            case ($urandom_range(5))
                0:       top_data = 16'd0;
                1:       top_data = 16'hFFFF;
                default: top_data = 16'($urandom);
            endcase
            apply_settings(step_data, interval_data, top_data);
            calm = (p == 4);
            for (int i = 0; i < per_phase; i++)
            begin
                op = ($urandom_range(99) < 20) ? OP_SET : OP_TICK;
                pick = $urandom_range(9);
                if (pick < 7)
                    req = 16'($urandom_range(0, 100));
                else if (pick == 7)
                    req = 16'($urandom_range(101, 65535));
                else
                    req = 16'($urandom);
                send_request(op, req);
            end
            calm = 1'b0;
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        mismatches = 0;
        cycle_count = 0;
        calm = 1'b0;
        step_pct_reg = STEP_RST;
        interval_ms_reg = INTERVAL_RST;
        timer_top_reg = TOP_RST;
        duty_pct = '0;
        target_pct = '0;
        elapsed_ms = '0;
        held_u = '0;
        held_v = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_ramp_up_clamp();
        test_ramp_down_clamp();
        test_zero_step_and_interval();
        test_interval_lowered();
        test_random_ramps(12, 160);

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_duty_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
